// ===== rtl/core/aabbfc_pkg.sv =====
// Shared types and constants for the box/frustum classifier.
// No dependencies; used by aabbfc_plane_eval and aabb_frustum_classifier_top.
`timescale 1ns / 1ps
`default_nettype none

package aabbfc_pkg;

    // Plane set and fixed-point format
    localparam int NUM_PLANES    = 6;
    localparam int NORMAL_FRAC   = 14;
    localparam int PLANE_FIELD_W = 16;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 4 * PLANE_FIELD_W;

    // One plane register: d in the top slot, nx in the bottom slot
    typedef struct packed {
        logic signed [PLANE_FIELD_W-1:0] d;
        logic signed [PLANE_FIELD_W-1:0] nz;
        logic signed [PLANE_FIELD_W-1:0] ny;
        logic signed [PLANE_FIELD_W-1:0] nx;
    } plane_t;

    // Classification result codes
    typedef enum logic [1:0] {
        VERDICT_INSIDE    = 2'd0,
        VERDICT_INTERSECT = 2'd1,
        VERDICT_OUTSIDE   = 2'd2
    } verdict_t;

    // Stage load enables handed to each plane slice
    typedef struct packed {
        logic load_prod;
        logic load_flag;
    } pipe_ctl_t;

    // Per-plane test outcome
    typedef struct packed {
        logic far_neg;
        logic near_nonpos;
    } plane_flags_t;

endpackage

`default_nettype wire

// ===== rtl/core/aabbfc_plane_eval.sv =====
// Two pipeline stages of the test against one plane: corner products, then distance signs.
// Depends on aabbfc_pkg (plane_t, pipe_ctl_t, plane_flags_t, PLANE_FIELD_W, NORMAL_FRAC).
`timescale 1ns / 1ps
`default_nettype none

module aabbfc_plane_eval #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                          clk,
    input  wire aabbfc_pkg::pipe_ctl_t         ctl,
    input  wire aabbfc_pkg::plane_t            plane,
    input  wire logic signed [COORD_WIDTH:0]   lo [3],
    input  wire logic signed [COORD_WIDTH:0]   hi [3],
    output aabbfc_pkg::plane_flags_t           flags
);

    localparam int PW = COORD_WIDTH + 1 + aabbfc_pkg::PLANE_FIELD_W;
    localparam int SW = PW + 3;

    logic signed [aabbfc_pkg::PLANE_FIELD_W-1:0] normal [3];
    logic signed [COORD_WIDTH:0] far_pt  [3];
    logic signed [COORD_WIDTH:0] near_pt [3];
    logic signed [PW-1:0] far_prod_reg   [3];
    logic signed [PW-1:0] far_prod_next  [3];
    logic signed [PW-1:0] near_prod_reg  [3];
    logic signed [PW-1:0] near_prod_next [3];
    logic signed [SW-1:0] d_term;
    logic signed [SW-1:0] dist_far;
    logic signed [SW-1:0] dist_near;
    aabbfc_pkg::plane_flags_t flags_reg;
    aabbfc_pkg::plane_flags_t flags_next;

    assign normal[0] = plane.nx;
    assign normal[1] = plane.ny;
    assign normal[2] = plane.nz;

    // Pick far and near corners per axis; a zero component counts as non-positive
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            if (!normal[a][aabbfc_pkg::PLANE_FIELD_W-1] && (normal[a] != '0))
            begin
                far_pt[a]  = hi[a];
                near_pt[a] = lo[a];
            end
            else
            begin
                far_pt[a]  = lo[a];
                near_pt[a] = hi[a];
            end
            far_prod_next[a]  = PW'(normal[a]) * PW'(far_pt[a]);
            near_prod_next[a] = PW'(normal[a]) * PW'(near_pt[a]);
        end
    end

    // Hold products for the summing stage
    always_ff @(posedge clk)
    begin
        if (ctl.load_prod)
        begin
            far_prod_reg  <= far_prod_next;
            near_prod_reg <= near_prod_next;
        end
    end

    // Sum products with the scaled offset and take the signs
    always_comb
    begin
        d_term    = SW'(plane.d) <<< aabbfc_pkg::NORMAL_FRAC;
        dist_far  = SW'(far_prod_reg[0]) + SW'(far_prod_reg[1])
                  + SW'(far_prod_reg[2]) + d_term;
        dist_near = SW'(near_prod_reg[0]) + SW'(near_prod_reg[1])
                  + SW'(near_prod_reg[2]) + d_term;
        flags_next.far_neg     = dist_far[SW-1];
        flags_next.near_nonpos = dist_near[SW-1] || (dist_near == '0);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_flag)
        begin
            flags_reg <= flags_next;
        end
    end

    assign flags = flags_reg;

endmodule

`default_nettype wire

// ===== rtl/core/aabb_frustum_classifier_top.sv =====
// Top level of the box/frustum classifier: plane registers, pipeline control, verdict.
// Depends on aabbfc_pkg and aabbfc_plane_eval.
`timescale 1ns / 1ps
`default_nettype none

// Classifies one axis-aligned box (center and half-extents) per cycle against six
// planes written through the configuration port, returning inside, intersecting or
// outside. Sustained rate is one box per clock while the output is not stalled; the
// result passes through four register stages: corner bounds, the normal-by-corner
// multipliers, the per-plane distance sum and sign test, and the verdict register
// that drives the output. A stall at the output backs up stage by stage, so empty
// stages keep filling while the result waits. Plane registers reset to zero, which
// makes every box intersecting until software loads the planes; write them only
// while no box is in flight.
module aabb_frustum_classifier_top #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output      logic                                 in_ready,
    input  wire logic signed [COORD_WIDTH-1:0]        center_x,
    input  wire logic signed [COORD_WIDTH-1:0]        center_y,
    input  wire logic signed [COORD_WIDTH-1:0]        center_z,
    input  wire logic [COORD_WIDTH-2:0]               half_x,
    input  wire logic [COORD_WIDTH-2:0]               half_y,
    input  wire logic [COORD_WIDTH-2:0]               half_z,
    output      logic                                 out_valid,
    input  wire logic                                 out_ready,
    output      logic [1:0]                           verdict,
    input  wire logic                                 cfg_valid,
    output      logic                                 cfg_ready,
    input  wire logic [aabbfc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [aabbfc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int NP = aabbfc_pkg::NUM_PLANES;

    aabbfc_pkg::plane_t plane_reg [NP];

    logic signed [COORD_WIDTH-1:0] center [3];
    logic [COORD_WIDTH-2:0]        half   [3];
    logic signed [COORD_WIDTH:0]   lo_next [3];
    logic signed [COORD_WIDTH:0]   hi_next [3];
    logic signed [COORD_WIDTH:0]   lo_reg  [3];
    logic signed [COORD_WIDTH:0]   hi_reg  [3];

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    aabbfc_pkg::pipe_ctl_t    ctl;
    aabbfc_pkg::plane_flags_t flags [NP];
    aabbfc_pkg::verdict_t     verdict_reg;
    aabbfc_pkg::verdict_t     verdict_next;

    // Configuration: always ready, ignore indexes past the plane set
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NP; i++)
            begin
                plane_reg[i] <= '0;
            end
        end
        else if (cfg_valid && (cfg_index < aabbfc_pkg::CFG_INDEX_W'(NP)))
        begin
            plane_reg[cfg_index] <= aabbfc_pkg::plane_t'(cfg_data);
        end
    end

    // Stage readiness: a stage loads when empty or when its contents move on
    assign rdy4 = !v4_reg || out_ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign ctl.load_prod = rdy2 && v1_reg;
    assign ctl.load_flag = rdy3 && v2_reg;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Stage 1: box bounds per axis
    assign center[0] = center_x;
    assign center[1] = center_y;
    assign center[2] = center_z;
    assign half[0]   = half_x;
    assign half[1]   = half_y;
    assign half[2]   = half_z;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            lo_next[a] = (COORD_WIDTH+1)'(center[a]) - (COORD_WIDTH+1)'($signed({1'b0, half[a]}));
            hi_next[a] = (COORD_WIDTH+1)'(center[a]) + (COORD_WIDTH+1)'($signed({1'b0, half[a]}));
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    // Stages 2 and 3: one slice per plane
    for (genvar p = 0; p < NP; p++)
    begin : g_plane
        aabbfc_plane_eval #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_plane_eval (
            .clk   (clk),
            .ctl   (ctl),
            .plane (plane_reg[p]),
            .lo    (lo_reg),
            .hi    (hi_reg),
            .flags (flags[p])
        );
    end

    // Stage 4: outside wins over intersecting
    always_comb
    begin
        logic any_out;
        logic any_touch;
        any_out   = 1'b0;
        any_touch = 1'b0;
        for (int p = 0; p < NP; p++)
        begin
            any_out   = any_out   || flags[p].far_neg;
            any_touch = any_touch || flags[p].near_nonpos;
        end
        if (any_out)
        begin
            verdict_next = aabbfc_pkg::VERDICT_OUTSIDE;
        end
        else if (any_touch)
        begin
            verdict_next = aabbfc_pkg::VERDICT_INTERSECT;
        end
        else
        begin
            verdict_next = aabbfc_pkg::VERDICT_INSIDE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && v3_reg)
        begin
            verdict_reg <= verdict_next;
        end
    end

    assign out_valid = v4_reg;
    assign verdict   = verdict_reg;

    // An open output leaves every stage free to load
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output was ready");

    // With the output held open, an accepted transaction moves through each stage and reaches the output
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
        else $error("transaction did not reach the output on time");

endmodule

`default_nettype wire
